>>> hdl/sha1mh_pkg.sv
// Package for the SHA-1 message hasher: sequencer states, initial hash
// values and round constants. No dependencies.
package sha1mh_pkg;

  typedef logic [31:0] word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } state_t;

  localparam int NUM_CHAIN = 5;
  localparam int NUM_SCHED = 16;

  localparam word_t IV_WORDS [NUM_CHAIN] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam word_t K_R0 = 32'h5A827999;
  localparam word_t K_R1 = 32'h6ED9EBA1;
  localparam word_t K_R2 = 32'h8F1BBCDC;
  localparam word_t K_R3 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [5:0] FILL_LAST  = 6'd63;
  localparam logic [5:0] FILL_LEN   = 6'd56;
  localparam logic [2:0] WORD_LAST  = 3'd4;

endpackage

>>> hdl/sha1_message_hasher.sv
// SHA-1 message hasher: byte packing, padding sequencer and one shared
// round unit with a 16-word rolling schedule. Depends on sha1mh_pkg.
//
// Usage: message bytes enter one word at a time on the in_ channel.
// in_tdata carries the byte, in_tuser[0] says whether the byte is present
// and in_tlast ends the message (a word with tlast and no byte is allowed,
// so empty messages hash too). A byte word is taken while the block is idle.
// Every 64th byte starts a compression (one SHA-1 round per cycle in the
// shared round unit, then the chaining add), and in_tready stays low until
// the chaining add is done.
// After tlast the block appends the padding byte by byte, one per cycle,
// runs one or two more compressions and then presents the digest as five
// 32-bit words on the out_ channel, most significant first, with the word
// position in out_tuser and out_tlast on the fifth.
// in_tready is low until the fifth word is taken; if the receiver stalls,
// the current word simply holds. After the fifth word the state returns to
// the initial hash values and a new message may start.
// Reset (rst_n low, synchronous) loads the initial hash values, clears the
// byte and bit counts and leaves the block idle and ready.
module sha1_message_hasher
  import sha1mh_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] byte_present
  input  logic        in_tlast,   // end_of_message
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r;
  logic [63:0] bit_cnt_r;
  logic [23:0] acc_r;
  word_t       w_r [NUM_SCHED];
  word_t       rr_r [NUM_CHAIN];
  word_t       chain_r [NUM_CHAIN];
  logic [6:0]  rnd_r;
  logic        finish_r;
  logic        sent80_r;
  logic        lenph_r;
  logic [2:0]  oidx_r;

  logic        in_acc, out_acc;
  logic        put_en;
  logic [7:0]  put_byte;
  logic        block_done;
  logic        len_sel;
  logic [7:0]  len_byte;
  word_t       w_new, w_cur, f_val, k_val, t_val;

  // Length bytes go out big-endian at fill positions 56 to 63.
  assign len_byte = 8'(bit_cnt_r >> {~fill_r[2:0], 3'b000});
  assign len_sel  = sent80_r && (lenph_r || (fill_r == FILL_LEN));

  assign in_acc     = in_tvalid && in_tready;
  assign out_acc    = out_tvalid && out_tready;
  assign block_done = put_en && (fill_r == FILL_LAST);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (block_done) begin
            state_nxt = ST_ROUND;
          end else if (in_tlast) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (block_done) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (rnd_r == ROUND_LAST) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        if (finish_r && lenph_r) begin
          state_nxt = ST_OUT;
        end else if (finish_r) begin
          state_nxt = ST_PAD;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_acc && (oidx_r == WORD_LAST)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Handshake and byte-path controls.
  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    put_en     = 1'b0;
    put_byte   = in_tdata;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        put_en    = in_tvalid && in_tuser[0];
      end
      ST_PAD: begin
        put_en = 1'b1;
        if (!sent80_r) begin
          put_byte = PAD_MARK;
        end else if (len_sel) begin
          put_byte = len_byte;
        end else begin
          put_byte = 8'h00;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  assign out_tdata = chain_r[oidx_r];
  assign out_tuser = oidx_r;
  assign out_tlast = (oidx_r == WORD_LAST);

  // Shared round unit. The schedule line holds W[t-16..t-1] at taps 0..15.
  assign w_new = {w_r[13][30:0] ^ w_r[8][30:0] ^ w_r[2][30:0] ^ w_r[0][30:0],
                  w_r[13][31] ^ w_r[8][31] ^ w_r[2][31] ^ w_r[0][31]};
  assign w_cur = (rnd_r < 7'd16) ? w_r[0] : w_new;

  always_comb begin
    if (rnd_r < 7'd20) begin
      f_val = (rr_r[1] & rr_r[2]) | (~rr_r[1] & rr_r[3]);
      k_val = K_R0;
    end else if (rnd_r < 7'd40) begin
      f_val = rr_r[1] ^ rr_r[2] ^ rr_r[3];
      k_val = K_R1;
    end else if (rnd_r < 7'd60) begin
      f_val = (rr_r[1] & rr_r[2]) | (rr_r[1] & rr_r[3]) | (rr_r[2] & rr_r[3]);
      k_val = K_R2;
    end else begin
      f_val = rr_r[1] ^ rr_r[2] ^ rr_r[3];
      k_val = K_R3;
    end
  end

  assign t_val = {rr_r[0][26:0], rr_r[0][31:27]} + f_val + rr_r[4] + k_val + w_cur;

  // Datapath without reset: byte accumulator, schedule line, working words.
  always_ff @(posedge clk) begin
    if (put_en) begin
      acc_r <= {acc_r[15:0], put_byte};
    end
    if (put_en && (fill_r[1:0] == 2'b11)) begin
      for (int i = 0; i < NUM_SCHED - 1; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[NUM_SCHED - 1] <= {acc_r, put_byte};
    end else if (state_r == ST_ROUND) begin
      for (int i = 0; i < NUM_SCHED - 1; i++) begin
        w_r[i] <= w_r[i + 1];
      end
      w_r[NUM_SCHED - 1] <= w_cur;
    end
    if (block_done) begin
      rr_r <= chain_r;
    end else if (state_r == ST_ROUND) begin
      rr_r[0] <= t_val;
      rr_r[1] <= rr_r[0];
      rr_r[2] <= {rr_r[1][1:0], rr_r[1][31:2]};
      rr_r[3] <= rr_r[2];
      rr_r[4] <= rr_r[3];
    end
  end

  // Control state and chaining words.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fill_r    <= '0;
      bit_cnt_r <= '0;
      chain_r   <= IV_WORDS;
      rnd_r     <= '0;
      finish_r  <= 1'b0;
      sent80_r  <= 1'b0;
      lenph_r   <= 1'b0;
      oidx_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (put_en) begin
        fill_r <= fill_r + 6'd1;
      end
      if (block_done) begin
        rnd_r <= '0;
      end else if (state_r == ST_ROUND) begin
        rnd_r <= (rnd_r == ROUND_LAST) ? 7'd0 : rnd_r + 7'd1;
      end
      if (in_acc) begin
        if (in_tuser[0]) begin
          bit_cnt_r <= bit_cnt_r + 64'd8;
        end
        if (in_tlast) begin
          finish_r <= 1'b1;
        end
      end
      if (state_r == ST_PAD) begin
        if (!sent80_r) begin
          sent80_r <= 1'b1;
        end else if (len_sel) begin
          lenph_r <= 1'b1;
        end
      end
      if (state_r == ST_ADD) begin
        for (int k = 0; k < NUM_CHAIN; k++) begin
          chain_r[k] <= chain_r[k] + rr_r[k];
        end
      end
      if (out_acc) begin
        if (oidx_r == WORD_LAST) begin
          // Start over with a fresh context for the next message.
          chain_r   <= IV_WORDS;
          fill_r    <= '0;
          bit_cnt_r <= '0;
          finish_r  <= 1'b0;
          sent80_r  <= 1'b0;
          lenph_r   <= 1'b0;
          oidx_r    <= '0;
        end else begin
          oidx_r <= oidx_r + 3'd1;
        end
      end
    end
  end

  // The round counter never runs past the last round.
  a_rnd_range: assert property (@(posedge clk) disable iff (!rst_n)
    rnd_r <= ROUND_LAST)
    else $error("round counter out of range");

  // A compression always starts on a fresh, empty block.
  a_round_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (fill_r == 6'd0))
    else $error("compression running with a partly filled block");

  // The input side and the digest side are never open together.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest pending");

  // The length is only appended after the 0x80 marker.
  a_len_order: assert property (@(posedge clk) disable iff (!rst_n)
    lenph_r |-> sent80_r)
    else $error("length bytes before the padding marker");

  // The digest is shown only once the length block has been absorbed.
  a_out_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (finish_r && lenph_r && (fill_r == 6'd0) && (oidx_r <= WORD_LAST)))
    else $error("digest presented before padding completed");

endmodule
